[src/bbc_pkg.sv]
// ----------------------------------------------------------------------------
// Block buffer cache package
// Shared widths, codes and result types of the block buffer cache directory.
// ----------------------------------------------------------------------------
package bbc_pkg;

   localparam int SLOTS       = 3;
   localparam int BLOCK_BYTES = 512;

   localparam int OP_W     = 2;
   localparam int BLOCK_W  = 24;
   localparam int POS_W    = BLOCK_W + 1;
   localparam int FILL_W   = 10;
   localparam int STATUS_W = 3;
   localparam int SLOT_W   = 2;
   localparam int AGE_W    = 16;
   localparam int SLOT_IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   localparam logic [AGE_W-1:0]       AGE_RESET = AGE_W'(1000);
   localparam logic [AGE_W-1:0]       AGE_MAX   = '1;
   localparam logic [FILL_W-1:0]      LEN_MAX   = FILL_W'(BLOCK_BYTES);
   localparam logic signed [POS_W-1:0] POS_NONE  = '1;
   localparam logic signed [POS_W-1:0] POS_MAX   = {1'b0, {BLOCK_W{1'b1}}};

   typedef enum logic [OP_W-1:0] {
      OP_SEEK = 2'd0,
      OP_NEXT = 2'd1,
      OP_PREV = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_HIT    = 3'd0,
      ST_FILLED = 3'd1,
      ST_BEFORE = 3'd2,
      ST_FAILED = 3'd3,
      ST_RANGE  = 3'd4,
      ST_SAME   = 3'd5
   } status_type;

   // Outcome of the position update for one transaction.
   typedef struct packed {
      logic                     lookup;
      status_type               status;
      logic signed [POS_W-1:0]  block;
   } pos_res_type;

   // Outcome of the directory lookup for one transaction.
   typedef struct packed {
      status_type              status;
      logic [SLOT_IDX_W-1:0]   slot;
      logic [FILL_W-1:0]       length;
   } dir_res_type;

endpackage

[src/bbc_req_if.sv]
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one cache request.
// ----------------------------------------------------------------------------
interface bbc_req_if;
   logic                         valid;
   logic                         ready;
   logic [bbc_pkg::OP_W-1:0]     operation;
   logic [bbc_pkg::BLOCK_W-1:0]  seek_block;
   logic [bbc_pkg::FILL_W-1:0]   fill_length;

   modport source (output valid, output operation, output seek_block,
                   output fill_length, input ready);
   modport sink   (input valid, input operation, input seek_block,
                   input fill_length, output ready);
endinterface

[src/bbc_rsp_if.sv]
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one cache result.
// ----------------------------------------------------------------------------
interface bbc_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [bbc_pkg::STATUS_W-1:0]       status;
   logic [bbc_pkg::SLOT_W-1:0]         slot;
   logic signed [bbc_pkg::POS_W-1:0]   block_number;
   logic [bbc_pkg::FILL_W-1:0]         valid_length;

   modport source (output valid, output status, output slot, output block_number,
                   output valid_length, input ready);
   modport sink   (input valid, input status, input slot, input block_number,
                   input valid_length, output ready);
endinterface

[src/bbc_pos.sv]
// ----------------------------------------------------------------------------
// Block position tracker
// Holds the current block number and applies seek, forward and backward moves.
// ----------------------------------------------------------------------------
module bbc_pos (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic [bbc_pkg::OP_W-1:0]      operation,
   input  logic [bbc_pkg::BLOCK_W-1:0]   seek_block,
   input  logic [bbc_pkg::BLOCK_W-1:0]   last_block,
   output bbc_pkg::pos_res_type          res
);

   logic signed [bbc_pkg::POS_W-1:0] block_ff;
   logic signed [bbc_pkg::POS_W-1:0] block_in;
   logic signed [bbc_pkg::POS_W-1:0] target;

   assign target = {1'b0, seek_block};

   always_comb begin
      block_in   = block_ff;
      res.lookup = 1'b0;
      res.status = bbc_pkg::ST_SAME;
      case (operation)
         bbc_pkg::OP_SEEK: begin
            // The same-block check comes before the range check.
            if (target == block_ff) begin
               res.status = bbc_pkg::ST_SAME;
            end else if (seek_block > last_block) begin
               res.status = bbc_pkg::ST_RANGE;
            end else begin
               block_in   = target;
               res.lookup = 1'b1;
            end
         end
         bbc_pkg::OP_NEXT: begin
            if (block_ff < bbc_pkg::POS_MAX) begin
               block_in = block_ff + bbc_pkg::POS_W'(1);
            end
            res.lookup = 1'b1;
         end
         bbc_pkg::OP_PREV: begin
            if (block_ff <= $signed(bbc_pkg::POS_W'(0))) begin
               block_in   = bbc_pkg::POS_NONE;
               res.status = bbc_pkg::ST_BEFORE;
            end else begin
               block_in   = block_ff - bbc_pkg::POS_W'(1);
               res.lookup = 1'b1;
            end
         end
         default: begin
            res.status = bbc_pkg::ST_SAME;
         end
      endcase
      res.block = block_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_ff <= bbc_pkg::POS_NONE;
      end else if (en) begin
         block_ff <= block_in;
      end
   end

endmodule

[src/bbc_dir.sv]
// ----------------------------------------------------------------------------
// Slot directory
// Tag lookup across the slots, oldest-slot refill and age bookkeeping.
// ----------------------------------------------------------------------------
module bbc_dir (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          lookup,
   input  logic [bbc_pkg::BLOCK_W-1:0]   tag,
   input  logic [bbc_pkg::FILL_W-1:0]    fill_length,
   output bbc_pkg::dir_res_type          res
);

   logic [bbc_pkg::SLOTS-1:0]          valid_ff;
   logic [bbc_pkg::SLOTS-1:0]          valid_in;
   logic [bbc_pkg::BLOCK_W-1:0]        tag_ff [bbc_pkg::SLOTS];
   logic [bbc_pkg::FILL_W-1:0]         len_ff [bbc_pkg::SLOTS];
   logic [bbc_pkg::AGE_W-1:0]          age_ff [bbc_pkg::SLOTS];
   logic [bbc_pkg::AGE_W-1:0]          age_in [bbc_pkg::SLOTS];

   logic                               hit;
   logic [bbc_pkg::SLOT_IDX_W-1:0]     hit_idx;
   logic [bbc_pkg::SLOT_IDX_W-1:0]     old_idx;
   logic [bbc_pkg::AGE_W-1:0]          old_age;
   logic [bbc_pkg::SLOT_IDX_W-1:0]     used;
   logic [bbc_pkg::FILL_W-1:0]         fill_cl;
   logic                               fill_ok;
   logic                               touch;

   always_comb begin
      // Scan from the top so that the lowest matching slot wins.
      hit     = 1'b0;
      hit_idx = '0;
      for (int i = bbc_pkg::SLOTS - 1; i >= 0; i--) begin
         if (valid_ff[i] && (tag_ff[i] == tag)) begin
            hit     = 1'b1;
            hit_idx = bbc_pkg::SLOT_IDX_W'(i);
         end
      end

      // Strictly greater keeps the first slot on an age tie.
      old_idx = '0;
      old_age = age_ff[0];
      for (int i = 1; i < bbc_pkg::SLOTS; i++) begin
         if (age_ff[i] > old_age) begin
            old_idx = bbc_pkg::SLOT_IDX_W'(i);
            old_age = age_ff[i];
         end
      end

      fill_cl = (fill_length > bbc_pkg::LEN_MAX) ? bbc_pkg::LEN_MAX : fill_length;
      fill_ok = lookup && !hit && (fill_length != '0);
      touch   = lookup && (hit || (fill_length != '0));
      used    = hit ? hit_idx : old_idx;

      valid_in = valid_ff;
      if (fill_ok) begin
         valid_in[used] = 1'b1;
      end

      for (int i = 0; i < bbc_pkg::SLOTS; i++) begin
         if (!touch) begin
            age_in[i] = age_ff[i];
         end else if (used == bbc_pkg::SLOT_IDX_W'(i)) begin
            age_in[i] = bbc_pkg::AGE_W'(1);
         end else if (age_ff[i] == bbc_pkg::AGE_MAX) begin
            age_in[i] = age_ff[i];
         end else begin
            age_in[i] = age_ff[i] + bbc_pkg::AGE_W'(1);
         end
      end

      res.slot   = used;
      if (hit) begin
         res.status = bbc_pkg::ST_HIT;
         res.length = len_ff[hit_idx];
      end else if (fill_length == '0) begin
         res.status = bbc_pkg::ST_FAILED;
         res.length = '0;
         res.slot   = '0;
      end else begin
         res.status = bbc_pkg::ST_FILLED;
         res.length = fill_cl;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         for (int i = 0; i < bbc_pkg::SLOTS; i++) begin
            age_ff[i] <= bbc_pkg::AGE_RESET;
         end
      end else if (en) begin
         valid_ff <= valid_in;
         for (int i = 0; i < bbc_pkg::SLOTS; i++) begin
            age_ff[i] <= age_in[i];
         end
      end
   end

   // Tags and lengths are only read behind a set valid bit.
   always_ff @(posedge clock) begin
      if (en && fill_ok) begin
         tag_ff[used] <= tag;
         len_ff[used] <= fill_cl;
      end
   end

endmodule

[src/block_buffer_cache_age_replace_unit.sv]
// A request waits in the input register, then its result in the result register,
// which offers it on the response channel.
// Throughput: one request per cycle unless responses stall; the input register and the
// result register both advance in the same cycle; slot state updates as the result registers.
// Reset (synchronous, active high): block number -1, all slots invalid, every age
// 1000, last_block 0, both channels empty.
// ----------------------------------------------------------------------------
// Block buffer cache age replacement unit
// Directory and oldest-slot replacement policy of a small block buffer cache.
// ----------------------------------------------------------------------------
module block_buffer_cache_age_replace_unit (
   input  logic                          clock,
   input  logic                          reset,
   bbc_req_if.sink                       req_ch,
   bbc_rsp_if.source                     rsp_ch,
   input  logic                          csr_wr_en,
   input  logic [bbc_pkg::BLOCK_W-1:0]   csr_wr_data
);

   logic [bbc_pkg::BLOCK_W-1:0]        last_block_ff;

   logic                               s1_valid_ff;
   logic                               s1_valid_in;
   logic [bbc_pkg::OP_W-1:0]           s1_op_ff;
   logic [bbc_pkg::BLOCK_W-1:0]        s1_seek_ff;
   logic [bbc_pkg::FILL_W-1:0]         s1_fill_ff;

   logic                               out_valid_ff;
   logic                               out_valid_in;
   bbc_pkg::status_type                out_status_ff;
   logic [bbc_pkg::SLOT_W-1:0]         out_slot_ff;
   logic signed [bbc_pkg::POS_W-1:0]   out_block_ff;
   logic [bbc_pkg::FILL_W-1:0]         out_len_ff;

   logic                               accept;
   logic                               advance;
   bbc_pkg::pos_res_type               pos_res;
   bbc_pkg::dir_res_type               dir_res;

   assign advance       = s1_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready  = !s1_valid_ff || advance;
   assign accept        = req_ch.valid && req_ch.ready;
   assign s1_valid_in   = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign out_valid_in  = advance ? 1'b1 : (rsp_ch.ready ? 1'b0 : out_valid_ff);

   bbc_pos u_pos (
      .clock      (clock),
      .reset      (reset),
      .en         (advance),
      .operation  (s1_op_ff),
      .seek_block (s1_seek_ff),
      .last_block (last_block_ff),
      .res        (pos_res)
   );

   bbc_dir u_dir (
      .clock       (clock),
      .reset       (reset),
      .en          (advance),
      .lookup      (pos_res.lookup),
      .tag         (pos_res.block[bbc_pkg::BLOCK_W-1:0]),
      .fill_length (s1_fill_ff),
      .res         (dir_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         last_block_ff <= '0;
         s1_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            last_block_ff <= csr_wr_data;
         end
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff   <= req_ch.operation;
         s1_seek_ff <= req_ch.seek_block;
         s1_fill_ff <= req_ch.fill_length;
      end
   end

   // Requests that skip the lookup report slot 0 and no valid bytes.
   always_ff @(posedge clock) begin
      if (advance) begin
         out_block_ff <= pos_res.block;
         if (pos_res.lookup) begin
            out_status_ff <= dir_res.status;
            out_slot_ff   <= bbc_pkg::SLOT_W'(dir_res.slot);
            out_len_ff    <= dir_res.length;
         end else begin
            out_status_ff <= pos_res.status;
            out_slot_ff   <= '0;
            out_len_ff    <= '0;
         end
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.status       = out_status_ff;
   assign rsp_ch.slot         = out_slot_ff;
   assign rsp_ch.block_number = out_block_ff;
   assign rsp_ch.valid_length = out_len_ff;

endmodule

[tb/bbc_directory_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block buffer cache directory checker
// Watches the request, response and register ports, predicts every response
// from its own copy of the directory and compares it field by field.
// ----------------------------------------------------------------------------
module bbc_directory_checker
   import bbc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   bbc_req_if                  req_mon,
   bbc_rsp_if                  rsp_mon,
   input  logic                csr_wr_en,
   input  logic [BLOCK_W-1:0]  csr_wr_data,
   output int                  mismatch_count,
   output int                  pending_count
);

   typedef struct packed {
      status_type               status;
      logic [SLOT_W-1:0]        slot;
      logic signed [POS_W-1:0]  block;
      logic [FILL_W-1:0]        length;
   } cache_rsp_type;

   logic [BLOCK_W-1:0]       seek_limit;
   logic signed [POS_W-1:0]  position;
   logic                     tag_valid  [SLOTS];
   logic [BLOCK_W-1:0]       tag_block  [SLOTS];
   logic [AGE_W-1:0]         slot_age   [SLOTS];
   logic [FILL_W-1:0]        slot_bytes [SLOTS];

   cache_rsp_type            due_responses [$];

   function automatic cache_rsp_type advance_directory(input logic [OP_W-1:0] op,
                                                       input logic [BLOCK_W-1:0] target,
                                                       input logic [FILL_W-1:0] fill);
      cache_rsp_type  r;
      logic           lookup;
      logic           found;
      int             used;
      int             i;
      r.status = ST_SAME;
      r.slot   = '0;
      r.length = '0;
      lookup   = 1'b0;
      found    = 1'b0;
      used     = 0;
      case (op)
         OP_SEEK: begin
            // A seek to the current block wins over the range check.
            if ({1'b0, target} == position) begin
               r.status = ST_SAME;
            end else if (target > seek_limit) begin
               r.status = ST_RANGE;
            end else begin
               position = {1'b0, target};
               lookup   = 1'b1;
            end
         end
         OP_NEXT: begin
            if (position < POS_MAX) position = position + POS_W'(1);
            lookup = 1'b1;
         end
         OP_PREV: begin
            if (position <= 0) begin
               position = POS_NONE;
               r.status = ST_BEFORE;
            end else begin
               position = position - POS_W'(1);
               lookup   = 1'b1;
            end
         end
         default: r.status = ST_SAME;
      endcase

      if (lookup) begin
         for (i = 0; i < SLOTS; i++) begin
            if (!found && tag_valid[i] && tag_block[i] == position[BLOCK_W-1:0]) begin
               found = 1'b1;
               used  = i;
            end
         end
         if (!found) begin
            // Oldest slot is the victim; the lowest index wins a tie.
            for (i = 1; i < SLOTS; i++) begin
               if (slot_age[i] > slot_age[used]) used = i;
            end
         end
         if (!found && fill == '0) begin
            r.status = ST_FAILED;
         end else begin
            if (!found) begin
               tag_valid[used]  = 1'b1;
               tag_block[used]  = position[BLOCK_W-1:0];
               slot_bytes[used] = (fill > LEN_MAX) ? LEN_MAX : fill;
            end
            slot_age[used] = '0;
            for (i = 0; i < SLOTS; i++) begin
               if (slot_age[i] != AGE_MAX) slot_age[i] = slot_age[i] + 1'b1;
            end
            r.status = found ? ST_HIT : ST_FILLED;
            r.slot   = SLOT_W'(used);
            r.length = slot_bytes[used];
         end
      end
      r.block = position;
      return r;
   endfunction

   always @(posedge clock) begin : watch
      cache_rsp_type  want;
      cache_rsp_type  got;
      int             i;
      if (reset) begin
         seek_limit = '0;
         position   = POS_NONE;
         for (i = 0; i < SLOTS; i++) begin
            tag_valid[i]  = 1'b0;
            tag_block[i]  = '0;
            slot_age[i]   = AGE_RESET;
            slot_bytes[i] = '0;
         end
         due_responses.delete();
         mismatch_count = 0;
      end else begin
         if (csr_wr_en) seek_limit = csr_wr_data;
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.status = status_type'(rsp_mon.status);
            got.slot   = rsp_mon.slot;
            got.block  = rsp_mon.block_number;
            got.length = rsp_mon.valid_length;
            if (due_responses.size() == 0) begin
               if (mismatch_count < 10)
                  $display({"%0t: response with nothing pending: ",
                            "status %0d slot %0d block %0d length %0d"},
                           $realtime, got.status, got.slot, got.block, got.length);
               mismatch_count++;
            end else begin
               want = due_responses.pop_front();
               if (got.status !== want.status || got.slot !== want.slot ||
                   got.block !== want.block || got.length !== want.length) begin
                  if (mismatch_count < 10)
                     $display({"%0t: response mismatch: expected status %0d slot %0d ",
                               "block %0d length %0d, got status %0d slot %0d ",
                               "block %0d length %0d"},
                              $realtime, want.status, want.slot, want.block,
                              want.length, got.status, got.slot, got.block,
                              got.length);
                  mismatch_count++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            due_responses.push_back(advance_directory(req_mon.operation, req_mon.seek_block,
                                                      req_mon.fill_length));
      end
      pending_count = due_responses.size();
   end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block buffer cache age replacement testbench
// Drives directed and random cache requests under several seek limits, with
// random idling on both channels, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_top;
   import bbc_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED  = 2'd3;
   localparam int              IDLE_LIMIT = 2000;
   localparam int              PHASE_ITEMS = 220;

   logic                clock;
   logic                reset;
   logic                csr_wr_en;
   logic [BLOCK_W-1:0]  csr_wr_data;
   int                  mismatch_count;
   int                  pending_count;
   int                  idle_cycles;
   int                  hold_off;
   bit                  steady;

   bbc_req_if req_ch ();
   bbc_rsp_if rsp_ch ();

   block_buffer_cache_age_replace_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   bbc_directory_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_ch),
      .rsp_mon        (rsp_ch),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset <= 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   // Response side: after each transaction the receiver may stall at random.
   always @(posedge clock) begin : receiver
      int draw;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         hold_off     <= 0;
      end else if (rsp_ch.valid && rsp_ch.ready) begin
         draw = steady ? 0 : $urandom_range(0, 3);
         rsp_ch.ready <= (draw == 0);
         hold_off     <= draw;
      end else if (hold_off != 0) begin
         rsp_ch.ready <= (hold_off == 1);
         hold_off     <= hold_off - 1;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
         $display("block_buffer_cache_age_replace_unit verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Leaves valid high after the transaction so a following request can go
   // out back to back; callers that pause lower it themselves.
   task automatic push_request(input logic [OP_W-1:0] op, input logic [BLOCK_W-1:0] target,
                               input logic [FILL_W-1:0] fill);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.operation   <= op;
      req_ch.seek_block  <= target;
      req_ch.fill_length <= fill;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic wait_for_results();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
      @(posedge clock);
   endtask

   task automatic write_last_block(input logic [BLOCK_W-1:0] value);
      wait_for_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic send_random(input logic [BLOCK_W-1:0] limit);
      int                  pick;
      logic [OP_W-1:0]     op;
      logic [BLOCK_W-1:0]  target;
      logic [FILL_W-1:0]   fill;
      pick = $urandom_range(0, 99);
      if (pick < 45)      op = OP_SEEK;
      else if (pick < 72) op = OP_NEXT;
      else if (pick < 97) op = OP_PREV;
      else                op = OP_UNUSED;
      // Most seeks stay in a narrow window so the slots get hit and reused.
      pick = $urandom_range(0, 99);
      if (pick < 30)      target = BLOCK_W'($urandom_range(0, (limit < 7) ? limit : 7));
      else if (pick < 55) target = BLOCK_W'($urandom_range(0, (limit < 63) ? limit : 63));
      else if (pick < 70) target = BLOCK_W'($urandom_range(0, limit));
      else if (pick < 80) target = limit;
      else if (pick < 88) target = (limit == '1) ? limit : limit + 1'b1;
      else                target = BLOCK_W'($urandom());
      pick = $urandom_range(0, 99);
      if (pick < 8)       fill = '0;
      else if (pick < 16) fill = FILL_W'($urandom_range(513, 1023));
      else if (pick < 21) fill = LEN_MAX;
      else                fill = FILL_W'($urandom_range(1, 511));
      push_request(op, target, fill);
   endtask

   initial begin : stimulus
      logic [BLOCK_W-1:0] limits [7];
      int p;
      int n;
      req_ch.valid       <= 1'b0;
      req_ch.operation   <= OP_SEEK;
      req_ch.seek_block  <= '0;
      req_ch.fill_length <= '0;
      csr_wr_en          <= 1'b0;
      csr_wr_data        <= '0;
      steady             = 1'b0;
      do @(posedge clock); while (reset);

      // Directed part with the reset seek limit of block 0.
      push_request(OP_PREV, '0, 10'd100);        // backward before any block
      push_request(OP_NEXT, '0, LEN_MAX);        // block 0 filled
      push_request(OP_PREV, '0, 10'd7);          // backward from block 0
      push_request(OP_SEEK, '0, 10'd9);          // seek back to block 0, hit
      push_request(OP_SEEK, '0, 10'd9);          // seek to the current block
      push_request(OP_SEEK, 24'd1, 10'd9);       // past the last block
      push_request(OP_UNUSED, 24'hFFFFFF, 10'h3FF);

      write_last_block('1);
      push_request(OP_SEEK, 24'hFFFFFF, '0);     // read fails, position still moves
      push_request(OP_NEXT, '0, 10'h3FF);        // saturated forward, oversized fill
      push_request(OP_NEXT, '0, 10'd1);          // hit at the top block
      push_request(OP_SEEK, '0, 10'd1);
      push_request(OP_SEEK, 24'd5, 10'd1);
      push_request(OP_SEEK, 24'd6, 10'd300);     // forces an eviction
      push_request(OP_PREV, '0, 10'd50);
      push_request(OP_SEEK, 24'hAAAAAA, 10'h155);
      push_request(OP_SEEK, 24'h555555, 10'h2AA);
      push_request(OP_SEEK, 24'hAAAAAA, 10'd0);
      push_request(OP_NEXT, '0, 10'd0);          // miss with a failed read
      push_request(OP_PREV, '0, 10'd511);
      push_request(OP_SEEK, 24'd1, 10'd0);
      push_request(OP_PREV, '0, 10'd0);          // down to block 0
      push_request(OP_PREV, '0, 10'd0);          // before start again

      // Back to back misses on fresh blocks, so the oldest slots are
      // evicted one after another with no idle cycles between them.
      wait_for_results();
      steady = 1'b1;
      push_request(OP_SEEK, 24'd3, 10'd64);
      push_request(OP_SEEK, 24'd11, 10'd64);
      push_request(OP_SEEK, 24'hFFFFFF, 10'd64);
      push_request(OP_SEEK, 24'd19, 10'd200);
      push_request(OP_SEEK, 24'd27, 10'd201);
      steady = 1'b0;

      limits[0] = '0;
      limits[1] = '1;
      limits[2] = 24'd7;
      limits[3] = 24'd40;
      limits[4] = BLOCK_W'($urandom());
      limits[5] = 24'd1;
      limits[6] = '1;
      for (p = 0; p < 7; p++) begin
         write_last_block(limits[p]);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 40 == 0) steady = ($urandom_range(0, 4) == 0);
            if (n % 150 == 149) wait_for_results();
            send_random(limits[p]);
         end
      end
      steady = 1'b0;

      wait_for_results();
      repeat (8) @(posedge clock);
      @(negedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("block_buffer_cache_age_replace_unit verification clean");
      end else begin
         $display("block_buffer_cache_age_replace_unit verification failed");
      end
      $finish;
   end

endmodule
